// ----- src/dlbm_pkg.sv -----
// ----------------------------------------------------------------------------
// dlbm_pkg: shared types and constants for the discrete latch bank mapper
// Kind codes, mirroring codes, address window decode and the FDS bank table.
// ----------------------------------------------------------------------------
package dlbm_pkg;

    localparam int PRG_BANK_BITS = 8;
    localparam int CHR_BANK_BITS = 8;

    localparam logic [7:0] PRG_WIDTH_MASK = 8'((1 << PRG_BANK_BITS) - 1);
    localparam logic [7:0] CHR_WIDTH_MASK = 8'((1 << CHR_BANK_BITS) - 1);

    localparam logic [5:0] K_UNROM  = 6'd0;
    localparam logic [5:0] K_CNROM  = 6'd1;
    localparam logic [5:0] K_ANROM  = 6'd2;
    localparam logic [5:0] K_M8     = 6'd3;
    localparam logic [5:0] K_M11    = 6'd4;
    localparam logic [5:0] K_CPROM  = 6'd5;
    localparam logic [5:0] K_M29    = 6'd6;
    localparam logic [5:0] K_M38    = 6'd7;
    localparam logic [5:0] K_M66    = 6'd8;
    localparam logic [5:0] K_M70    = 6'd9;
    localparam logic [5:0] K_M78    = 6'd10;
    localparam logic [5:0] K_M86    = 6'd11;
    localparam logic [5:0] K_M87    = 6'd12;
    localparam logic [5:0] K_M89    = 6'd13;
    localparam logic [5:0] K_M93    = 6'd14;
    localparam logic [5:0] K_M94    = 6'd15;
    localparam logic [5:0] K_M97    = 6'd16;
    localparam logic [5:0] K_M101   = 6'd17;
    localparam logic [5:0] K_M107   = 6'd18;
    localparam logic [5:0] K_M113   = 6'd19;
    localparam logic [5:0] K_M152   = 6'd20;
    localparam logic [5:0] K_M180   = 6'd21;
    localparam logic [5:0] K_M184   = 6'd22;
    localparam logic [5:0] K_M203   = 6'd23;
    localparam logic [5:0] K_M240   = 6'd24;
    localparam logic [5:0] K_M241   = 6'd25;
    localparam logic [5:0] K_M11160 = 6'd26;
    localparam logic [5:0] K_M538   = 6'd27;
    localparam logic [5:0] K_K3046  = 6'd28;
    localparam logic [5:0] K_M381   = 6'd29;
    localparam logic [5:0] K_M415   = 6'd30;
    localparam logic [5:0] K_M462   = 6'd31;
    localparam logic [5:0] K_M429   = 6'd32;
    localparam logic [5:0] K_M764   = 6'd33;
    localparam logic [5:0] K_M271   = 6'd34;
    localparam logic [5:0] K_M740   = 6'd35;
    localparam logic [5:0] K_M481   = 6'd36;
    localparam logic [5:0] K_M477   = 6'd37;
    localparam logic [5:0] KIND_COUNT = 6'd38;

    localparam logic [2:0] MIR_H     = 3'd0;
    localparam logic [2:0] MIR_V     = 3'd1;
    localparam logic [2:0] MIR_SA    = 3'd2;
    localparam logic [2:0] MIR_SB    = 3'd3;
    localparam logic [2:0] MIR_3A1B  = 3'd4;
    localparam logic [2:0] MIR_FIXED = 3'd5;
    localparam logic [2:0] MIR_NONE  = 3'd7;

    localparam logic [2:0] REG_KIND     = 3'd0;
    localparam logic [2:0] REG_SUB      = 3'd1;
    localparam logic [2:0] REG_CONFLICT = 3'd2;
    localparam logic [2:0] REG_LATCH    = 3'd3;
    localparam logic [2:0] REG_PRG_MASK = 3'd4;
    localparam logic [2:0] REG_CHR_MASK = 3'd5;

    localparam logic REQ_WRITE      = 1'b0;
    localparam logic REQ_SOFT_RESET = 1'b1;

    typedef struct packed {
        logic [7:0] pg6;
        logic [7:0] pg0;
        logic [7:0] pg1;
        logic [7:0] pg2;
        logic [7:0] pg3;
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [2:0] mir;
    } bank_map_t;

    function automatic logic [7:0] fds_bank(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:               r = 8'd0;
            4'd2:               r = 8'd2;
            4'd4:               r = 8'd3;
            4'd6:               r = 8'd4;
            4'd8, 4'd9:         r = 8'd5;
            4'd12, 4'd13:       r = 8'd6;
            4'd14, 4'd15:       r = 8'd7;
            default:            r = 8'd1;
        endcase
        return r;
    endfunction

    function automatic logic win_hit(input logic [5:0] kind, input logic [15:0] addr);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = 16'h8000;
        hi = 16'hFFFF;
        case (kind)
            K_ANROM:  lo = 16'h4020;
            K_M38:    begin lo = 16'h7000; hi = 16'h7FFF; end
            K_M86:    begin lo = 16'h6000; hi = 16'h6FFF; end
            K_M87:    lo = 16'h6000;
            K_M101:   begin lo = 16'h6000; hi = 16'h7FFF; end
            K_M113:   begin lo = 16'h4100; hi = 16'h7FFF; end
            K_M184:   begin lo = 16'h6000; hi = 16'h7FFF; end
            K_M240:   begin lo = 16'h4020; hi = 16'h5FFF; end
            K_M538:   begin lo = 16'hC000; hi = 16'hCFFF; end
            default:  ;
        endcase
        return (kind < KIND_COUNT) && (addr >= lo) && (addr <= hi);
    endfunction

endpackage

// ----- src/dlbm_req_if.sv -----
// ----------------------------------------------------------------------------
// dlbm_req_if: bus access word channel
// Valid/ready channel carrying one CPU write or soft reset event.
// ----------------------------------------------------------------------------
interface dlbm_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] cpu_addr;
    logic [7:0]  cpu_data;
    logic [7:0]  rom_data;

    modport source (output valid, req_type, cpu_addr, cpu_data, rom_data, input ready);
    modport sink   (input valid, req_type, cpu_addr, cpu_data, rom_data, output ready);
endinterface

// ----- src/dlbm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dlbm_rsp_if: bank result word channel
// Valid/ready channel carrying the bank numbers and mirroring after a word.
// ----------------------------------------------------------------------------
interface dlbm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] prg_bank_6000;
    logic [7:0] prg_bank_8000;
    logic [7:0] prg_bank_a000;
    logic [7:0] prg_bank_c000;
    logic [7:0] prg_bank_e000;
    logic [7:0] chr_bank_low;
    logic [7:0] chr_bank_high;
    logic [2:0] mirror_mode;
    logic [7:0] latch_value;

    modport source (output valid, prg_bank_6000, prg_bank_8000, prg_bank_a000,
                    prg_bank_c000, prg_bank_e000, chr_bank_low, chr_bank_high,
                    mirror_mode, latch_value, input ready);
    modport sink   (input valid, prg_bank_6000, prg_bank_8000, prg_bank_a000,
                    prg_bank_c000, prg_bank_e000, chr_bank_low, chr_bank_high,
                    mirror_mode, latch_value, output ready);
endinterface

// ----- src/dlbm_bank_map.sv -----
// ----------------------------------------------------------------------------
// dlbm_bank_map: per-kind bank decode
// Turns latch, outer bank and toggle state into raw PRG/CHR banks and mirroring.
// ----------------------------------------------------------------------------
module dlbm_bank_map (
    input  logic [5:0]           kind,
    input  logic [3:0]           sub_variant,
    input  logic [7:0]           latch,
    input  logic [7:0]           outer,
    input  logic                 toggle,
    output dlbm_pkg::bank_map_t  banks
);
    import dlbm_pkg::*;

    function automatic logic [7:0] dbl(input logic [7:0] v, input logic b);
        return {v[6:0], b};
    endfunction

    function automatic logic [7:0] quad(input logic [7:0] v, input logic [1:0] i);
        return {v[5:0], i};
    endfunction

    logic [7:0] L;
    logic [7:0] t;
    logic [7:0] ob;

    always_comb
    begin
        L = latch;
        t = 8'd0;
        ob = 8'd0;
        banks.pg6 = 8'd0;
        banks.pg0 = 8'd0;
        banks.pg1 = 8'd1;
        banks.pg2 = 8'd2;
        banks.pg3 = 8'd3;
        banks.ch0 = 8'd0;
        banks.ch1 = 8'd1;
        banks.mir = MIR_NONE;
        case (kind)
            K_UNROM:
            begin
                banks.pg0 = dbl(L, 1'b0); banks.pg1 = dbl(L, 1'b1);
                banks.pg2 = 8'hFE; banks.pg3 = 8'hFF;
            end
            K_CNROM, K_M101:
            begin
                banks.ch0 = dbl(L, 1'b0); banks.ch1 = dbl(L, 1'b1);
            end
            K_ANROM:
            begin
                t = {4'd0, L[3:0]};
                banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                banks.mir = {2'b01, L[4]};
            end
            K_M8:
            begin
                t = {3'd0, L[7:3]};
                banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                banks.pg2 = 8'd2; banks.pg3 = 8'd3;
                t = {6'd0, L[1:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_M11:
            begin
                t = {4'd0, L[3:0]};
                banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                t = {4'd0, L[7:4]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_CPROM:
            begin
                banks.ch0 = 8'd0; banks.ch1 = {6'd0, L[1:0]};
            end
            K_M29:
            begin
                t = {5'd0, L[4:2]};
                banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                banks.pg2 = 8'hFE; banks.pg3 = 8'hFF;
                t = {6'd0, L[1:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_M38:
            begin
                t = {6'd0, L[1:0]};
                banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                t = {2'd0, L[7:2]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_M66, K_M240:
            begin
                t = {4'd0, L[7:4]};
                banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                t = {4'd0, L[3:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_M70:
            begin
                t = {4'd0, L[7:4]};
                banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                banks.pg2 = 8'hFE; banks.pg3 = 8'hFF;
                t = {4'd0, L[3:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_M78:
            begin
                t = {5'd0, L[2:0]};
                banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                banks.pg2 = 8'hFE; banks.pg3 = 8'hFF;
                t = {4'd0, L[7:4]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
                banks.mir = (sub_variant == 4'd3) ? {2'b00, L[3]} : {2'b01, L[3]};
            end
            K_M86:
            begin
                t = {6'd0, L[5:4]};
                banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                t = {5'd0, L[6], L[1:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_M87:
            begin
                t = {6'd0, L[0], L[1]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_M89:
            begin
                t = {5'd0, L[6:4]};
                banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                banks.pg2 = 8'hFE; banks.pg3 = 8'hFF;
                t = {4'd0, L[7], L[2:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
                banks.mir = {2'b01, L[3]};
            end
            K_M93:
            begin
                t = {4'd0, L[7:4]};
                banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                banks.pg2 = 8'hFE; banks.pg3 = 8'hFF;
            end
            K_M94:
            begin
                t = {2'd0, L[7:2]};
                banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                banks.pg2 = 8'hFE; banks.pg3 = 8'hFF;
            end
            K_M97:
            begin
                banks.pg0 = 8'hFE; banks.pg1 = 8'hFF;
                t = {4'd0, L[3:0]};
                banks.pg2 = dbl(t, 1'b0); banks.pg3 = dbl(t, 1'b1);
                if (L[7:6] == 2'd1)
                    banks.mir = MIR_H;
                else if (L[7:6] == 2'd2)
                    banks.mir = MIR_V;
                t = {6'd0, L[0], L[1]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_M107:
            begin
                t = {6'd0, L[2:1]};
                banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                t = {5'd0, L[2:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_M113:
            begin
                t = {5'd0, L[5:3]};
                banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                t = {4'd0, L[6], L[2:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_M152:
            begin
                t = {5'd0, L[6:4]};
                banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                banks.pg2 = 8'hFE; banks.pg3 = 8'hFF;
                t = {4'd0, L[3:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
                banks.mir = {2'b01, L[7]};
            end
            K_M180:
            begin
                banks.pg0 = 8'd0; banks.pg1 = 8'd1;
                banks.pg2 = dbl(L, 1'b0); banks.pg3 = dbl(L, 1'b1);
            end
            K_M184:
            begin
                banks.ch0 = L; banks.ch1 = {4'd0, L[7:4]};
            end
            K_M203:
            begin
                t = {2'd0, L[7:2]};
                banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                banks.pg2 = dbl(t, 1'b0); banks.pg3 = dbl(t, 1'b1);
                t = {6'd0, L[1:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
            end
            K_M241:
            begin
                t = L[7] ? (L | 8'h08) : L;
                banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
            end
            K_M11160:
            begin
                t = {5'd0, L[6:4]};
                banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                t = {3'd0, L[6:4], L[1:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
                banks.mir = {2'b00, L[7]};
            end
            K_M538:
            begin
                banks.pg6 = {1'b0, L[7:1]} | 8'h08;
                banks.pg0 = fds_bank(L[3:0]);
                banks.pg1 = 8'd14; banks.pg2 = 8'd7; banks.pg3 = 8'd15;
                banks.mir = MIR_V;
            end
            K_K3046:
            begin
                banks.pg0 = dbl(L, 1'b0); banks.pg1 = dbl(L, 1'b1);
                t = L | 8'h07;
                banks.pg2 = dbl(t, 1'b0); banks.pg3 = dbl(t, 1'b1);
                if (sub_variant == 4'd2)
                    banks.mir = L[3] ? MIR_H : MIR_V;
                else
                    banks.mir = L[5] ? MIR_H : MIR_V;
            end
            K_M381:
            begin
                t = {3'd0, toggle, L[2:0], L[4]};
                banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                t = {3'd0, toggle, 4'hF};
                banks.pg2 = dbl(t, 1'b0); banks.pg3 = dbl(t, 1'b1);
            end
            K_M415:
            begin
                banks.pg6 = {4'd0, L[3:0]};
                banks.pg0 = 8'hFC; banks.pg1 = 8'hFD;
                banks.pg2 = 8'hFE; banks.pg3 = 8'hFF;
                banks.mir = {2'b00, ~L[4]};
            end
            K_M462:
            begin
                if (outer[6])
                begin
                    t = {3'd0, outer[7:6], L[2:0]} & 8'h1F;
                    t = {3'd0, outer[7:6] & 2'b11, L[2:0]};
                    t = {3'd0, outer[7], outer[6], L[2:0]};
                    banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                    banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                    banks.mir = L[4] ? MIR_SB : MIR_SA;
                end
                else
                begin
                    ob = {2'd0, outer[7:5], 3'd0};
                    t = ob | {5'd0, L[2:0]};
                    banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                    t = ob | 8'h07;
                    banks.pg2 = dbl(t, 1'b0); banks.pg3 = dbl(t, 1'b1);
                    banks.mir = outer[4] ? MIR_V : MIR_H;
                end
            end
            K_M429:
            begin
                t = {2'd0, L[7:2]};
                banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                if (sub_variant == 4'd2)
                    t = {5'd0, L[2] & L[3], L[1:0]};
                else
                    t = L;
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
                if (sub_variant == 4'd1)
                    banks.mir = L[7] ? MIR_SB : MIR_SA;
            end
            K_M764:
            begin
                if (L[6])
                begin
                    t = {1'b0, L[7:1]};
                    banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                    banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                end
                else
                begin
                    banks.pg0 = dbl(L, 1'b0); banks.pg1 = dbl(L, 1'b1);
                    t = L | 8'h07;
                    banks.pg2 = dbl(t, 1'b0); banks.pg3 = dbl(t, 1'b1);
                end
                banks.mir = L[5] ? MIR_H : MIR_V;
            end
            K_M271:
            begin
                t = {4'd0, L[3:0]};
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
                t = {4'd0, L[7:4]};
                banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                banks.mir = {2'b00, L[5]};
            end
            K_M740:
            begin
                t = {3'd0, L[4:0]};
                if (L[4:0] == 5'd2)
                begin
                    ob = {4'd0, L[4:1]};
                    banks.pg0 = quad(ob, 2'd0); banks.pg1 = quad(ob, 2'd1);
                    banks.pg2 = quad(ob, 2'd2); banks.pg3 = quad(ob, 2'd3);
                end
                else
                begin
                    banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                    banks.pg2 = dbl(t, 1'b0); banks.pg3 = dbl(t, 1'b1);
                end
                banks.ch0 = dbl(t, 1'b0); banks.ch1 = dbl(t, 1'b1);
                case (L[7:6])
                    2'd0:    banks.mir = MIR_3A1B;
                    2'd1:    banks.mir = MIR_V;
                    2'd2:    banks.mir = MIR_H;
                    default: banks.mir = MIR_SB;
                endcase
            end
            K_M481:
            begin
                t = {4'd0, L[7], L[2:0]};
                banks.pg0 = dbl(t, 1'b0); banks.pg1 = dbl(t, 1'b1);
                t = {4'd0, L[7:4]} | 8'h07;
                banks.pg2 = dbl(t, 1'b0); banks.pg3 = dbl(t, 1'b1);
            end
            K_M477:
            begin
                if (L[3:1] != 3'd0)
                begin
                    banks.pg0 = 8'hFE; banks.pg1 = 8'hFF;
                    banks.pg2 = dbl(L, 1'b0); banks.pg3 = dbl(L, 1'b1);
                end
                else
                begin
                    t = {1'b0, L[7:1]};
                    banks.pg0 = quad(t, 2'd0); banks.pg1 = quad(t, 2'd1);
                    banks.pg2 = quad(t, 2'd2); banks.pg3 = quad(t, 2'd3);
                end
                banks.ch0 = dbl(L, 1'b0); banks.ch1 = dbl(L, 1'b1);
            end
            default:
            begin
                banks.pg1 = 8'd0; banks.pg2 = 8'd0; banks.pg3 = 8'd0;
                banks.ch1 = 8'd0;
            end
        endcase
    end

endmodule

// ----- src/discrete_latch_bank_mapper_core.sv -----
// ----------------------------------------------------------------------------
// discrete_latch_bank_mapper_core: discrete cartridge bank latch, 38 kinds
// One word per cycle in and one bank result word per cycle out, unless the result side stalls.
// ----------------------------------------------------------------------------
// Each accepted word (a CPU write or a soft reset event) updates the latch
// state and produces one registered result word, carrying the 8KB PRG
// banks, the 4KB CHR banks, the mirroring code and the latch contents. A new
// word is taken every cycle; the single result register is the only stage, so
// the input stalls only while a result is held by a stalled downstream side.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle;
// writing the initial latch value also loads the latch.
module discrete_latch_bank_mapper_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    dlbm_req_if.sink             req,
    dlbm_rsp_if.source           rsp
);
    import dlbm_pkg::*;

    logic [5:0] kind_reg;
    logic [3:0] sub_reg;
    logic       conflict_reg;
    logic [7:0] prg_mask_reg;
    logic [7:0] chr_mask_reg;

    logic [7:0] latch_reg, latch_next;
    logic [7:0] outer_reg, outer_next;
    logic       toggle_reg, toggle_next;
    logic [2:0] hold_reg, hold_next;

    logic       valid_reg;
    logic [7:0] pg6_reg, pg0_reg, pg1_reg, pg2_reg, pg3_reg, ch0_reg, ch1_reg;
    logic [2:0] mir_reg;
    logic [7:0] lv_reg;

    logic       accept;
    logic [7:0] pm;
    logic [7:0] cm;
    bank_map_t  banks;

    assign accept = req.valid && req.ready;
    assign req.ready = !valid_reg || rsp.ready;
    assign pm = prg_mask_reg & PRG_WIDTH_MASK;
    assign cm = chr_mask_reg & CHR_WIDTH_MASK;

    always_comb
    begin
        latch_next = latch_reg;
        outer_next = outer_reg;
        toggle_next = toggle_reg;
        if (req.req_type == REQ_WRITE)
        begin
            if (win_hit(kind_reg, req.cpu_addr))
            begin
                if (kind_reg == K_M462 && req.cpu_addr[15:13] == 3'b101)
                    outer_next = req.cpu_data;
                else if (kind_reg == K_M477)
                    latch_next = latch_reg[3]
                        ? ((req.rom_data & 8'h0F) | (req.cpu_data & req.rom_data & 8'hF0))
                        : (req.rom_data & req.cpu_data);
                else if (kind_reg == K_K3046 && sub_reg == 4'd1)
                    latch_next = (req.rom_data & 8'h08)
                        | (req.cpu_data & req.rom_data & 8'hF7);
                else
                    latch_next = conflict_reg ? (req.cpu_data & req.rom_data)
                                              : req.cpu_data;
            end
        end
        else
        begin
            case (kind_reg)
                K_K3046, K_M477: latch_next = 8'd0;
                K_M429:          latch_next = 8'd4;
                K_M381:          toggle_next = ~toggle_reg;
                K_M462:          outer_next = 8'd0;
                default:         ;
            endcase
        end
    end

    dlbm_bank_map u_map (
        .kind        (kind_reg),
        .sub_variant (sub_reg),
        .latch       (latch_next),
        .outer       (outer_next),
        .toggle      (toggle_next),
        .banks       (banks)
    );

    assign hold_next = (banks.mir == MIR_NONE) ? hold_reg : banks.mir;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= K_UNROM;
            sub_reg      <= 4'd0;
            conflict_reg <= 1'b0;
            prg_mask_reg <= 8'hFF;
            chr_mask_reg <= 8'hFF;
            latch_reg    <= 8'd0;
            outer_reg    <= 8'd0;
            toggle_reg   <= 1'b0;
            hold_reg     <= MIR_FIXED;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                latch_reg  <= latch_next;
                outer_reg  <= outer_next;
                toggle_reg <= toggle_next;
                hold_reg   <= hold_next;
                valid_reg  <= 1'b1;
            end
            else if (rsp.ready)
            begin
                valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KIND:     kind_reg <= cfg_data[5:0];
                    REG_SUB:      sub_reg <= cfg_data[3:0];
                    REG_CONFLICT: conflict_reg <= cfg_data[0];
                    REG_LATCH:    latch_reg <= cfg_data;
                    REG_PRG_MASK: prg_mask_reg <= cfg_data;
                    REG_CHR_MASK: chr_mask_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pg6_reg <= banks.pg6 & pm;
            pg0_reg <= banks.pg0 & pm;
            pg1_reg <= banks.pg1 & pm;
            pg2_reg <= banks.pg2 & pm;
            pg3_reg <= banks.pg3 & pm;
            ch0_reg <= banks.ch0 & cm;
            ch1_reg <= banks.ch1 & cm;
            mir_reg <= hold_next;
            lv_reg  <= latch_next;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.prg_bank_6000 = pg6_reg;
    assign rsp.prg_bank_8000 = pg0_reg;
    assign rsp.prg_bank_a000 = pg1_reg;
    assign rsp.prg_bank_c000 = pg2_reg;
    assign rsp.prg_bank_e000 = pg3_reg;
    assign rsp.chr_bank_low  = ch0_reg;
    assign rsp.chr_bank_high = ch1_reg;
    assign rsp.mirror_mode   = mir_reg;
    assign rsp.latch_value   = lv_reg;

endmodule

// ----- verif/dlbm_tb_if.sv -----
// ----------------------------------------------------------------------------
// dlbm_tb_if: test channel interfaces
// The block's own request and result interfaces are used directly; this file
// only holds the bus word type used by the stimulus.
// ----------------------------------------------------------------------------
package dlbm_tb_pkg;
    typedef struct packed {
        logic        req_type;
        logic [15:0] cpu_addr;
        logic [7:0]  cpu_data;
        logic [7:0]  rom_data;
    } bus_word_t;
endpackage

// ----- verif/dlbm_bank_checker.sv -----
// ----------------------------------------------------------------------------
// dlbm_bank_checker: bank mapping predictor and result scoreboard
// Mirrors configuration writes, predicts bank numbers, mirroring and latch
// contents for each accepted word, and compares every accepted result word.
// ----------------------------------------------------------------------------
module dlbm_bank_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    dlbm_req_if        req,
    dlbm_rsp_if        rsp,
    output int         errors,
    output int         pending,
    output int         results_seen
);
    import dlbm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic [5:0] kind;
    logic [3:0] sub;
    logic       conflict;
    logic [7:0] prg_mask;
    logic [7:0] chr_mask;
    logic [7:0] latch;
    logic [7:0] outer;
    logic       toggle;
    logic [2:0] mir_hold;

    bank_map_t  expected_banks[$];
    logic [7:0] expected_latch[$];

    logic [7:0] pg6;
    logic [7:0] pg[4];
    logic [7:0] ch[2];
    logic [2:0] mir;

    function automatic logic [7:0] fds_lookup(input logic [3:0] i);
        logic [7:0] tbl[16];
        tbl = '{0, 1, 2, 1, 3, 1, 4, 1, 5, 5, 1, 1, 6, 6, 7, 7};
        return tbl[i];
    endfunction

    function automatic logic in_window(input logic [5:0] k, input logic [15:0] a);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = 16'h8000;
        hi = 16'hFFFF;
        if (k == K_ANROM) lo = 16'h4020;
        else if (k == K_M38) begin lo = 16'h7000; hi = 16'h7FFF; end
        else if (k == K_M86) begin lo = 16'h6000; hi = 16'h6FFF; end
        else if (k == K_M87) lo = 16'h6000;
        else if (k == K_M101 || k == K_M184) begin lo = 16'h6000; hi = 16'h7FFF; end
        else if (k == K_M113) begin lo = 16'h4100; hi = 16'h7FFF; end
        else if (k == K_M240) begin lo = 16'h4020; hi = 16'h5FFF; end
        else if (k == K_M538) begin lo = 16'hC000; hi = 16'hCFFF; end
        return k < KIND_COUNT && a >= lo && a <= hi;
    endfunction

    task automatic set16(input int slot, input int v);
        pg[slot]     = 8'(2 * v);
        pg[slot + 1] = 8'(2 * v + 1);
    endtask

    task automatic set32(input int v);
        for (int i = 0; i < 4; i++) pg[i] = 8'(4 * v + i);
    endtask

    task automatic setc8(input int v);
        ch[0] = 8'(2 * v);
        ch[1] = 8'(2 * v + 1);
    endtask

    task automatic map_latch();
        int L;
        int t;
        int o;
        L = latch;
        pg6 = 0;
        set32(0);
        setc8(0);
        mir = MIR_NONE;
        case (kind)
            K_UNROM:  begin set16(0, L); set16(2, -1); end
            K_CNROM:  setc8(L);
            K_ANROM:  begin set32(L & 15); mir = 3'(2 + ((L >> 4) & 1)); end
            K_M8:     begin set16(0, L >> 3); set16(2, 1); setc8(L & 3); end
            K_M11:    begin set32(L & 15); setc8(L >> 4); end
            K_CPROM:  begin ch[0] = 0; ch[1] = 8'(L & 3); end
            K_M29:    begin set16(0, (L & 8'h1C) >> 2); set16(2, -1); setc8(L & 3); end
            K_M38:    begin set32(L & 3); setc8(L >> 2); end
            K_M66:    begin set32(L >> 4); setc8(L & 15); end
            K_M70:    begin set16(0, L >> 4); set16(2, -1); setc8(L & 15); end
            K_M78:
            begin
                set16(0, L & 7); set16(2, -1); setc8(L >> 4);
                mir = (sub == 3) ? 3'((L >> 3) & 1) : 3'(2 + ((L >> 3) & 1));
            end
            K_M86:    begin set32((L >> 4) & 3); setc8((L & 3) | ((L >> 4) & 4)); end
            K_M87:    setc8(((L >> 1) & 1) | ((L << 1) & 2));
            K_M89:
            begin
                set16(0, (L >> 4) & 7); set16(2, -1); setc8((L & 7) | ((L >> 4) & 8));
                mir = 3'(2 + ((L >> 3) & 1));
            end
            K_M93:    begin set16(0, L >> 4); set16(2, -1); end
            K_M94:    begin set16(0, L >> 2); set16(2, -1); end
            K_M97:
            begin
                set16(0, -1); set16(2, L & 15);
                t = L >> 6;
                if (t == 1) mir = MIR_H;
                else if (t == 2) mir = MIR_V;
                setc8(((L >> 1) & 1) | ((L << 1) & 2));
            end
            K_M101:   setc8(L);
            K_M107:   begin set32((L >> 1) & 3); setc8(L & 7); end
            K_M113:   begin set32((L >> 3) & 7); setc8(((L >> 3) & 8) | (L & 7)); end
            K_M152:
            begin
                set16(0, (L >> 4) & 7); set16(2, -1); setc8(L & 15);
                mir = 3'(2 + ((L >> 7) & 1));
            end
            K_M180:   begin set16(0, 0); set16(2, L); end
            K_M184:   begin ch[0] = 8'(L); ch[1] = 8'(L >> 4); end
            K_M203:   begin set16(0, L >> 2); set16(2, L >> 2); setc8(L & 3); end
            K_M240:   begin set32(L >> 4); setc8(L & 15); end
            K_M241:   set32((L & 8'h80) ? (L | 8) : L);
            K_M11160:
            begin
                t = (L >> 4) & 7; set32(t); setc8((t << 2) | (L & 3));
                mir = 3'((L >> 7) & 1);
            end
            K_M538:
            begin
                pg6 = 8'((L >> 1) | 8); pg[0] = fds_lookup(4'(L));
                pg[1] = 14; pg[2] = 7; pg[3] = 15; mir = MIR_V;
            end
            K_K3046:
            begin
                set16(0, L); set16(2, L | 7);
                mir = (L & ((sub == 2) ? 8'h08 : 8'h20)) ? MIR_H : MIR_V;
            end
            K_M381:
            begin
                t = toggle;
                set16(0, ((L & 8'h10) >> 4) | ((L & 7) << 1) | (t << 4));
                set16(2, 15 | (t << 4));
            end
            K_M415:
            begin
                pg6 = 8'(L & 15); set32(-1); mir = 3'(((L >> 4) & 1) ^ 1);
            end
            K_M462:
            begin
                o = outer;
                if (o & 8'h40)
                begin
                    set32((L & 7) | ((o >> 3) & ~7));
                    mir = (L & 8'h10) ? MIR_SB : MIR_SA;
                end
                else
                begin
                    set16(0, (L & 7) | ((o >> 2) & ~7));
                    set16(2, 7 | ((o >> 2) & ~7));
                    mir = (o & 8'h10) ? MIR_V : MIR_H;
                end
            end
            K_M429:
            begin
                set32(L >> 2);
                if (sub == 2) setc8((L & 3) | (((L & 4) && (L & 8)) ? 4 : 0));
                else setc8(L);
                if (sub == 1) mir = (L & 8'h80) ? MIR_SB : MIR_SA;
            end
            K_M764:
            begin
                if (L & 8'h40) set32(L >> 1);
                else begin set16(0, L); set16(2, L | 7); end
                mir = (L & 8'h20) ? MIR_H : MIR_V;
            end
            K_M271:   begin setc8(L & 15); set32(L >> 4); mir = 3'((L >> 5) & 1); end
            K_M740:
            begin
                if ((L & 8'h1F) == 2) set32((L >> 1) & 15);
                else begin set16(0, L & 31); set16(2, L & 31); end
                setc8(L & 31);
                t = L >> 6;
                mir = (t == 0) ? MIR_3A1B : (t == 1) ? MIR_V : (t == 2) ? MIR_H : MIR_SB;
            end
            K_M481:   begin set16(0, ((L >> 4) & ~7) | (L & 7)); set16(2, (L >> 4) | 7); end
            K_M477:
            begin
                if (L & 8'h0E) begin set16(0, 255); set16(2, L); end
                else set32(L >> 1);
                setc8(L);
            end
            default:
            begin
                for (int i = 0; i < 4; i++) pg[i] = 8'd0;
                ch[0] = 8'd0;
                ch[1] = 8'd0;
            end
        endcase
    endtask

    task automatic predict_word(input logic rt, input logic [15:0] a,
                                input logic [7:0] d, input logic [7:0] r);
        bank_map_t m;
        logic [7:0] pm;
        logic [7:0] cm;
        pm = prg_mask & PRG_WIDTH_MASK;
        cm = chr_mask & CHR_WIDTH_MASK;
        if (rt == REQ_WRITE)
        begin
            if (in_window(kind, a))
            begin
                if (kind == K_M462 && a >= 16'hA000 && a <= 16'hBFFF) outer = d;
                else if (kind == K_M477)
                    latch = latch[3] ? ((r & 8'h0F) | (d & r & 8'hF0)) : (r & d);
                else if (kind == K_K3046 && sub == 1)
                    latch = (r & 8'h08) | (d & r & 8'hF7);
                else latch = conflict ? (d & r) : d;
            end
        end
        else
        begin
            if (kind == K_K3046 || kind == K_M477) latch = 0;
            else if (kind == K_M429) latch = 4;
            else if (kind == K_M381) toggle = ~toggle;
            else if (kind == K_M462) outer = 0;
        end
        map_latch();
        if (mir == MIR_NONE) mir = mir_hold;
        mir_hold = mir;
        m.pg6 = pg6 & pm;
        m.pg0 = pg[0] & pm;
        m.pg1 = pg[1] & pm;
        m.pg2 = pg[2] & pm;
        m.pg3 = pg[3] & pm;
        m.ch0 = ch[0] & cm;
        m.ch1 = ch[1] & cm;
        m.mir = mir;
        expected_banks.push_back(m);
        expected_latch.push_back(latch);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    assign pending = expected_banks.size();

    always @(posedge clk or negedge rst_n)
    begin
        bank_map_t e;
        logic [7:0] el;
        if (!rst_n)
        begin
            kind = 0; sub = 0; conflict = 0; prg_mask = 255; chr_mask = 255;
            latch = 0; outer = 0; toggle = 0; mir_hold = MIR_FIXED;
            errors = 0; results_seen = 0;
            expected_banks.delete();
            expected_latch.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (expected_banks.size() == 0)
                begin
                    $error("result word with no expectation");
                    errors++;
                end
                else
                begin
                    e = expected_banks.pop_front();
                    el = expected_latch.pop_front();
                    check_field("prg_bank_6000", e.pg6, rsp.prg_bank_6000);
                    check_field("prg_bank_8000", e.pg0, rsp.prg_bank_8000);
                    check_field("prg_bank_a000", e.pg1, rsp.prg_bank_a000);
                    check_field("prg_bank_c000", e.pg2, rsp.prg_bank_c000);
                    check_field("prg_bank_e000", e.pg3, rsp.prg_bank_e000);
                    check_field("chr_bank_low", e.ch0, rsp.chr_bank_low);
                    check_field("chr_bank_high", e.ch1, rsp.chr_bank_high);
                    check_field("mirror_mode", e.mir, rsp.mirror_mode);
                    check_field("latch_value", el, rsp.latch_value);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KIND:     kind = cfg_data[5:0];
                    REG_SUB:      sub = cfg_data[3:0];
                    REG_CONFLICT: conflict = cfg_data[0];
                    REG_LATCH:    latch = cfg_data;
                    REG_PRG_MASK: prg_mask = cfg_data;
                    REG_CHR_MASK: chr_mask = cfg_data;
                    default:      ;
                endcase
            end
            if (req.valid && req.ready)
                predict_word(req.req_type, req.cpu_addr, req.cpu_data, req.rom_data);
        end
    end
endmodule

// ----- verif/discrete_latch_bank_mapper_core_test.sv -----
// ----------------------------------------------------------------------------
// discrete_latch_bank_mapper_core_test: bank mapper testbench top
// Sweeps every kind with random board settings, directed and random bus words,
// random gaps on both channels and a long result stall; the checker scores.
// ----------------------------------------------------------------------------
module discrete_latch_bank_mapper_core_test;
    import dlbm_pkg::*;
    import dlbm_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    int         errors;
    int         pending;
    int         results_seen;
    int         cycles = 0;
    int         words_sent;
    bit         long_hold;

    dlbm_req_if req();
    dlbm_rsp_if rsp();

    discrete_latch_bank_mapper_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    dlbm_bank_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req          (req),
        .rsp          (rsp),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        int g;
        bit held;
        held = 1'b0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold && !held)
            begin
                rsp.ready <= 1'b0;
                repeat (60) @(negedge clk);
                held = 1'b1;
            end
            g = gap_len();
            if (g == 0) rsp.ready <= 1'b1;
            else
            begin
                rsp.ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(input bus_word_t w, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= w.req_type;
        req.cpu_addr <= w.cpu_addr;
        req.cpu_data <= w.cpu_data;
        req.rom_data <= w.rom_data;
        do @(posedge clk); while (!req.ready);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic bus_word_t random_word(input logic [5:0] k);
        bus_word_t w;
        int p;
        w.req_type = ($urandom_range(0, 15) == 0);
        w.cpu_data = 8'($urandom);
        w.rom_data = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        p = $urandom_range(0, 9);
        if (p < 6)
        begin
            case (k)
                K_ANROM, K_M240: w.cpu_addr = 16'($urandom_range(16'h4020, 16'h5FFF));
                K_M38:           w.cpu_addr = 16'($urandom_range(16'h7000, 16'h7FFF));
                K_M86:           w.cpu_addr = 16'($urandom_range(16'h6000, 16'h6FFF));
                K_M101, K_M184:  w.cpu_addr = 16'($urandom_range(16'h6000, 16'h7FFF));
                K_M113:          w.cpu_addr = 16'($urandom_range(16'h4100, 16'h7FFF));
                K_M538:          w.cpu_addr = 16'($urandom_range(16'hC000, 16'hCFFF));
                default:         w.cpu_addr = 16'($urandom_range(16'h8000, 16'hFFFF));
            endcase
        end
        else if (p < 8) w.cpu_addr = 16'($urandom_range(16'h8000, 16'hFFFF));
        else w.cpu_addr = 16'($urandom);
        return w;
    endfunction

    initial
    begin
        bus_word_t w;
        logic [5:0] k;
        logic [7:0] edge_vals[4];
        edge_vals = '{8'h00, 8'hFF, 8'h0F, 8'hF0};
        words_sent = 0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KIND;
        cfg_data = 8'h00;
        req.valid = 1'b0;
        req.req_type = REQ_WRITE;
        req.cpu_addr = 16'h0000;
        req.cpu_data = 8'h00;
        req.rom_data = 8'h00;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, soft reset, outer bank and partial conflicts
        w = '{REQ_WRITE, 16'hFFFF, 8'hFF, 8'hFF};       send_word(w, 1'b0);
        w = '{REQ_WRITE, 16'h0000, 8'h00, 8'h00};       send_word(w, 1'b0);
        w = '{REQ_WRITE, 16'h8000, 8'hA5, 8'h5A};       send_word(w, 1'b0);
        w = '{REQ_SOFT_RESET, 16'h8000, 8'h00, 8'h00};  send_word(w, 1'b0);
        wait_drained();
        cfg_write(REG_KIND, 8'(K_M462));
        w = '{REQ_WRITE, 16'hA000, 8'h50, 8'h00};       send_word(w, 1'b0);
        w = '{REQ_WRITE, 16'h8000, 8'h17, 8'h00};       send_word(w, 1'b0);
        w = '{REQ_WRITE, 16'hBFFF, 8'hFF, 8'h00};       send_word(w, 1'b0);
        w = '{REQ_SOFT_RESET, 16'h0000, 8'h00, 8'h00};  send_word(w, 1'b0);
        wait_drained();
        cfg_write(REG_KIND, 8'(K_K3046));
        cfg_write(REG_SUB, 8'd1);
        w = '{REQ_WRITE, 16'h8000, 8'hF7, 8'h0F};       send_word(w, 1'b0);
        w = '{REQ_SOFT_RESET, 16'h8000, 8'h00, 8'h00};  send_word(w, 1'b0);
        wait_drained();
        cfg_write(REG_KIND, 8'(K_M477));
        w = '{REQ_WRITE, 16'h8000, 8'hFF, 8'h08};       send_word(w, 1'b0);
        w = '{REQ_WRITE, 16'h8000, 8'h3C, 8'hF5};       send_word(w, 1'b0);
        w = '{REQ_SOFT_RESET, 16'h8000, 8'h00, 8'h00};  send_word(w, 1'b0);
        wait_drained();
        cfg_write(REG_KIND, 8'd63);
        w = '{REQ_WRITE, 16'h8000, 8'h12, 8'hFF};       send_word(w, 1'b0);
        w = '{REQ_SOFT_RESET, 16'h8000, 8'h00, 8'h00};  send_word(w, 1'b0);
        wait_drained();

        // random sweep over kinds and board settings
        for (int phase = 0; phase < 48; phase++)
        begin
            k = (phase < 38) ? 6'(phase) : 6'($urandom_range(0, 63));
            cfg_write(REG_KIND, 8'(k));
            cfg_write(REG_SUB, 8'(4'($urandom_range(0, 3) == 0 ? $urandom
                                                              : $urandom_range(0, 3))));
            cfg_write(REG_CONFLICT, 8'($urandom_range(0, 1)));
            cfg_write(REG_LATCH, (phase < 4) ? edge_vals[phase] : 8'($urandom));
            cfg_write(REG_PRG_MASK, (phase % 3 == 0) ? 8'hFF :
                      (phase % 3 == 1) ? 8'h00 : 8'($urandom));
            cfg_write(REG_CHR_MASK, (phase % 4 == 0) ? 8'hFF :
                      (phase % 4 == 1) ? 8'h00 : 8'($urandom));
            if (phase == 20) long_hold = 1'b1;
            for (int n = 0; n < 21; n++)
            begin
                w = random_word(k);
                send_word(w, phase % 5 != 4);
            end
            wait_drained();
        end

        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        $display("Covered %0d bus words over all 38 kinds plus out-of-range kinds,",
                 words_sent);
        $display("with %0d result words checked under random stalls.", results_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
